FILE: rtl/core/sik_pkg.sv
// Shared types, widths and constants for the swerve inverse kinematics core.
// No dependencies; imported by the interfaces and every module of the core.
package sik_pkg;

	// Field widths
	localparam int IN_W     = 16;
	localparam int CFG_W    = 16;
	localparam int ANG_W    = 15;
	localparam int SPD_W    = 15;
	localparam int NWHEEL   = 4;

	// Internal widths
	localparam int PROD_W   = 33;          // rotation x half dimension
	localparam int ROT_W    = 19;          // rounded rotation term
	localparam int WXY_W    = 20;          // wheel vector component
	localparam int SQ_W     = 2 * WXY_W;   // square and root work width
	localparam int MAG_W    = 21;          // rounded magnitude
	localparam int CV_W     = 40;          // CORDIC x/y
	localparam int Z_W      = 27;          // CORDIC angle, 1/65536 degree
	localparam int DV_W     = 36;          // divider remainder
	localparam int DEG_SH   = 16;          // 1/65536 degree scale
	localparam int ANG_SH   = 10;          // 1/65536 -> 1/64 degree
	localparam int FRAC     = 14;          // Q.14

	localparam int MAX_STEPS  = 24;
	localparam int SQRT_STEPS = SQ_W / 2;
	localparam int DIV_STEPS  = SPD_W;

	localparam logic [CFG_W-1:0] HALF_RST = CFG_W'(8192);
	localparam logic signed [PROD_W-1:0] HALF_Q14 = PROD_W'(8192);
	localparam logic [MAG_W-1:0] ONE_Q14 = MAG_W'(16384);
	localparam logic [SPD_W-1:0] SPD_MAX = SPD_W'(16384);

	localparam logic signed [Z_W-1:0] Z_DEG180 = Z_W'(180 * 65536);
	localparam logic signed [Z_W-1:0] Z_DEG360 = Z_W'(360 * 65536);
	localparam logic signed [Z_W-1:0] Z_RND    = Z_W'(512);

	// Angle codes for the axis cases, 1/64 degree
	localparam logic [ANG_W-1:0] ANG_90  = ANG_W'(5760);
	localparam logic [ANG_W-1:0] ANG_180 = ANG_W'(11520);
	localparam logic [ANG_W-1:0] ANG_270 = ANG_W'(17280);
	localparam logic [ANG_W-1:0] ANG_360 = ANG_W'(23040);

	// Configuration register index
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HALF_LENGTH = 1'b0,
		REG_HALF_WIDTH  = 1'b1
	} cfg_reg_t;

	typedef logic signed [IN_W-1:0]  cmd_t;
	typedef logic signed [WXY_W-1:0] wxy_t;
	typedef logic [MAG_W-1:0]        mag_t;
	typedef logic [ANG_W-1:0]        ang_t;
	typedef logic [SPD_W-1:0]        spd_t;

	// atan(2^-i) in 1/65536 degree
	function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] i);
		logic signed [Z_W-1:0] a;
		case (i)
			5'd0:  a = Z_W'(2949120);
			5'd1:  a = Z_W'(1740967);
			5'd2:  a = Z_W'(919879);
			5'd3:  a = Z_W'(466945);
			5'd4:  a = Z_W'(234379);
			5'd5:  a = Z_W'(117304);
			5'd6:  a = Z_W'(58666);
			5'd7:  a = Z_W'(29335);
			5'd8:  a = Z_W'(14668);
			5'd9:  a = Z_W'(7334);
			5'd10: a = Z_W'(3667);
			5'd11: a = Z_W'(1833);
			5'd12: a = Z_W'(917);
			5'd13: a = Z_W'(458);
			5'd14: a = Z_W'(229);
			5'd15: a = Z_W'(115);
			5'd16: a = Z_W'(57);
			5'd17: a = Z_W'(29);
			5'd18: a = Z_W'(14);
			5'd19: a = Z_W'(7);
			5'd20: a = Z_W'(4);
			5'd21: a = Z_W'(2);
			5'd22: a = Z_W'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

FILE: rtl/core/sik_if.sv
// Valid/ready channel interfaces for chassis commands and wheel results.
// Depends on sik_pkg.
interface sik_cmd_if;
	import sik_pkg::*;
	logic valid;
	logic ready;
	cmd_t x_speed;
	cmd_t y_speed;
	cmd_t rotation;
	modport source(output valid, x_speed, y_speed, rotation, input ready);
	modport sink(input valid, x_speed, y_speed, rotation, output ready);
endinterface

interface sik_res_if;
	import sik_pkg::*;
	logic valid;
	logic ready;
	ang_t front_right_angle;
	spd_t front_right_speed;
	ang_t front_left_angle;
	spd_t front_left_speed;
	ang_t rear_right_angle;
	spd_t rear_right_speed;
	ang_t rear_left_angle;
	spd_t rear_left_speed;
	modport source(output valid, front_right_angle, front_right_speed, front_left_angle,
		front_left_speed, rear_right_angle, rear_right_speed, rear_left_angle,
		rear_left_speed, input ready);
	modport sink(input valid, front_right_angle, front_right_speed, front_left_angle,
		front_left_speed, rear_right_angle, rear_right_speed, rear_left_angle,
		rear_left_speed, output ready);
endinterface

FILE: rtl/core/swerve_inverse_kinematics_top.sv
// Four-wheel swerve inverse kinematics: command in, angle and speed per wheel out.
// Depends on sik_pkg, sik_if, sik_wheel, sik_norm.
//
//   channel  dir  content
//   cmd      in   x_speed, y_speed, rotation (Q1.14)
//   res      out  angle (1/64 deg) and speed (Q1.14) for FR, FL, RR, RL
//   cfg      in   cfg_we, cfg_index, cfg_data: half_length (0), half_width (1)
//
// One command per cycle while the output is not stalled; the latency is set by
// the CORDIC/root stage chain in each wheel and the 15-bit divider.
// All stages advance together whenever the output register is empty or taken;
// a stalled output freezes the whole pipe. Reset clears the valid bits and
// sets both half dimensions to 0.5.
module swerve_inverse_kinematics_top #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sik_cmd_if.sink                       cmd,
	sik_res_if.source                     res,
	input  logic                          cfg_we,
	input  logic [sik_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sik_pkg::CFG_W-1:0]     cfg_data
);
	import sik_pkg::*;

	localparam int CS  = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
	localparam int ND  = (CS > SQRT_STEPS) ? CS : SQRT_STEPS;
	localparam int LAT = ND + 23;

	logic [CFG_W-1:0] half_length_q, half_width_q;
	logic             adv;
	logic [LAT:1]     vld_s;

	logic signed [PROD_W-1:0] prod_l, prod_w, prod_l_s1, prod_w_s1;
	logic signed [PROD_W-1:0] tl_r, tw_r;
	logic signed [ROT_W-1:0]  tl, tw;
	cmd_t xs_s1, ys_s1;
	wxy_t xs_e, ys_e, tl_e, tw_e;
	wxy_t x_s2 [NWHEEL];
	wxy_t y_s2 [NWHEEL];
	ang_t ang_w [NWHEEL];
	mag_t mag_w [NWHEEL];
	spd_t spd_o [NWHEEL];
	ang_t ang_o [NWHEEL];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_length_q <= HALF_RST;
			half_width_q  <= HALF_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_HALF_LENGTH: half_length_q <= cfg_data;
				REG_HALF_WIDTH:  half_width_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Global advance; valid bits ride alongside the data
	assign adv       = !vld_s[LAT] || res.ready;
	assign cmd.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-1:1], cmd.valid};
		end
	end

	// Stage 1: rotation products
	assign prod_l = cmd.rotation * $signed({1'b0, half_length_q});
	assign prod_w = cmd.rotation * $signed({1'b0, half_width_q});

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_l_s1 <= prod_l;
			prod_w_s1 <= prod_w;
			xs_s1     <= cmd.x_speed;
			ys_s1     <= cmd.y_speed;
		end
	end

	// Stage 2: round half up, then wheel vectors
	assign tl_r = prod_l_s1 + HALF_Q14;
	assign tw_r = prod_w_s1 + HALF_Q14;
	assign tl   = tl_r[PROD_W-1:FRAC];
	assign tw   = tw_r[PROD_W-1:FRAC];
	assign xs_e = WXY_W'(xs_s1);
	assign ys_e = WXY_W'(ys_s1);
	assign tl_e = WXY_W'(tl);
	assign tw_e = WXY_W'(tw);

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2[0] <= xs_e + tl_e;
			y_s2[0] <= ys_e - tw_e;
			x_s2[1] <= xs_e + tl_e;
			y_s2[1] <= ys_e + tw_e;
			x_s2[2] <= xs_e - tl_e;
			y_s2[2] <= ys_e - tw_e;
			x_s2[3] <= xs_e - tl_e;
			y_s2[3] <= ys_e + tw_e;
		end
	end

	for (genvar w = 0; w < NWHEEL; w++) begin : g_wheel
		sik_wheel #(
			.CS (CS),
			.ND (ND)
		) u_wheel (
			.clk   (clk),
			.en    (adv),
			.x     (x_s2[w]),
			.y     (y_s2[w]),
			.angle (ang_w[w]),
			.mag   (mag_w[w])
		);
	end

	sik_norm u_norm (
		.clk    (clk),
		.en     (adv),
		.mag    (mag_w),
		.ang_in (ang_w),
		.speed  (spd_o),
		.angle  (ang_o)
	);

	// Result beat
	assign res.valid             = vld_s[LAT];
	assign res.front_right_angle = ang_o[0];
	assign res.front_right_speed = spd_o[0];
	assign res.front_left_angle  = ang_o[1];
	assign res.front_left_speed  = spd_o[1];
	assign res.rear_right_angle  = ang_o[2];
	assign res.rear_right_speed  = spd_o[2];
	assign res.rear_left_angle   = ang_o[3];
	assign res.rear_left_speed   = spd_o[3];

	// Input only backs up behind a held result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> (res.valid && !res.ready))
		else $error("input stalled without a held result");

	a_angle_rng: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.front_right_angle <= ANG_360 && res.front_left_angle <= ANG_360
			&& res.rear_right_angle <= ANG_360 && res.rear_left_angle <= ANG_360))
		else $error("wheel angle above 360 degrees");

	a_speed_rng: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.front_right_speed <= SPD_MAX && res.front_left_speed <= SPD_MAX
			&& res.rear_right_speed <= SPD_MAX && res.rear_left_speed <= SPD_MAX))
		else $error("wheel speed above 1.0");

endmodule

FILE: rtl/core/sik_wheel.sv
// One wheel: pipelined vectoring CORDIC for the angle and digit-by-digit
// square root for the magnitude, ND + 3 stages. Depends on sik_pkg.
module sik_wheel #(
	parameter int CS = 16,
	parameter int ND = 20
) (
	input  logic           clk,
	input  logic           en,
	input  sik_pkg::wxy_t  x,
	input  sik_pkg::wxy_t  y,
	output sik_pkg::ang_t  angle,
	output sik_pkg::mag_t  mag
);
	import sik_pkg::*;

	typedef struct packed {
		logic spec;
		ang_t ang;
	} spec_t;

	logic signed [SQ_W-1:0] sqx, sqy;
	logic signed [CV_W-1:0] xe, ye;
	spec_t sp_n;

	logic [SQ_W-1:0]        sx_s1, sy_s1;
	logic signed [CV_W-1:0] u_s1, v_s1;
	logic signed [Z_W-1:0]  z_s1;
	spec_t                  sp_s1;

	logic signed [CV_W-1:0] u_s [ND+1];
	logic signed [CV_W-1:0] v_s [ND+1];
	logic signed [Z_W-1:0]  z_s [ND+1];
	logic [SQ_W-1:0]        rem_s [ND+1];
	logic [SQ_W-1:0]        r_s [ND+1];
	spec_t                  sp_s [ND+1];

	// Squares and CORDIC setup
	assign sqx = x * x;
	assign sqy = y * y;
	assign xe = {{(CV_W-WXY_W-DEG_SH){x[WXY_W-1]}}, x, {DEG_SH{1'b0}}};
	assign ye = {{(CV_W-WXY_W-DEG_SH){y[WXY_W-1]}}, y, {DEG_SH{1'b0}}};

	// Axis and origin cases bypass the CORDIC
	always_comb begin
		sp_n.spec = 1'b0;
		sp_n.ang  = ANG_180;
		if (x == '0 && y == '0) begin
			sp_n.spec = 1'b1;
			sp_n.ang  = ANG_180;
		end else if (y == '0) begin
			sp_n.spec = 1'b1;
			sp_n.ang  = x[WXY_W-1] ? ANG_90 : ANG_270;
		end else if (x == '0) begin
			sp_n.spec = 1'b1;
			sp_n.ang  = y[WXY_W-1] ? ANG_360 : ANG_180;
		end
	end

	// z starts with the +180 offset folded in; left half plane adds another 180
	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= unsigned'(sqx);
			sy_s1 <= unsigned'(sqy);
			sp_s1 <= sp_n;
			if (y[WXY_W-1]) begin
				u_s1 <= -ye;
				v_s1 <= -xe;
				z_s1 <= Z_DEG360;
			end else begin
				u_s1 <= ye;
				v_s1 <= xe;
				z_s1 <= Z_DEG180;
			end
		end
	end

	// Sum of squares
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= sx_s1 + sy_s1;
			r_s[0]   <= '0;
			u_s[0]   <= u_s1;
			v_s[0]   <= v_s1;
			z_s[0]   <= z_s1;
			sp_s[0]  <= sp_s1;
		end
	end

	// One CORDIC step per stage for k < CS and one root digit per stage for k < SQRT_STEPS; else pass through
	for (genvar k = 0; k < ND; k++) begin : g_it
		logic signed [CV_W-1:0] u_n, v_n;
		logic signed [Z_W-1:0]  z_n;
		logic [SQ_W-1:0]        rem_n, r_n;

		if (k < CS) begin : g_rot
			localparam logic signed [Z_W-1:0] ATAN_K = atan_lut(5'(k));
			always_comb begin
				if (!v_s[k][CV_W-1]) begin
					u_n = u_s[k] + (v_s[k] >>> k);
					v_n = v_s[k] - (u_s[k] >>> k);
					z_n = z_s[k] + ATAN_K;
				end else begin
					u_n = u_s[k] - (v_s[k] >>> k);
					v_n = v_s[k] + (u_s[k] >>> k);
					z_n = z_s[k] - ATAN_K;
				end
			end
		end else begin : g_rot_pass
			assign u_n = u_s[k];
			assign v_n = v_s[k];
			assign z_n = z_s[k];
		end

		if (k < SQRT_STEPS) begin : g_sq
			localparam logic [SQ_W-1:0] SBIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
			logic [SQ_W-1:0] trial;
			assign trial = r_s[k] + SBIT;
			always_comb begin
				if (rem_s[k] >= trial) begin
					rem_n = rem_s[k] - trial;
					r_n   = (r_s[k] >> 1) + SBIT;
				end else begin
					rem_n = rem_s[k];
					r_n   = r_s[k] >> 1;
				end
			end
		end else begin : g_sq_pass
			assign rem_n = rem_s[k];
			assign r_n   = r_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				u_s[k+1]   <= u_n;
				v_s[k+1]   <= v_n;
				z_s[k+1]   <= z_n;
				rem_s[k+1] <= rem_n;
				r_s[k+1]   <= r_n;
				sp_s[k+1]  <= sp_s[k];
			end
		end
	end

	// Wrap into (0, 360], round to 1/64 degree; round the root
	logic signed [Z_W-1:0] t_a, t_b;
	logic [MAG_W-1:0]      r_f;
	assign t_a = z_s[ND] + Z_RND;
	assign t_b = z_s[ND] - Z_DEG360 + Z_RND;
	assign r_f = r_s[ND][MAG_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			if (sp_s[ND].spec) begin
				angle <= sp_s[ND].ang;
			end else if (z_s[ND] > Z_DEG360) begin
				angle <= t_b[ANG_SH+ANG_W-1:ANG_SH];
			end else begin
				angle <= t_a[ANG_SH+ANG_W-1:ANG_SH];
			end
			mag <= (rem_s[ND] > r_s[ND]) ? r_f + MAG_W'(1) : r_f;
		end
	end

endmodule

FILE: rtl/core/sik_norm.sv
// Speed normalization: largest magnitude, then a pipelined restoring divider
// per wheel, one quotient bit per stage; 18 stages. Depends on sik_pkg.
module sik_norm (
	input  logic          clk,
	input  logic          en,
	input  sik_pkg::mag_t mag [sik_pkg::NWHEEL],
	input  sik_pkg::ang_t ang_in [sik_pkg::NWHEEL],
	output sik_pkg::spd_t speed [sik_pkg::NWHEEL],
	output sik_pkg::ang_t angle [sik_pkg::NWHEEL]
);
	import sik_pkg::*;

	mag_t mab_s1, mcd_s1;
	mag_t mag_s1 [NWHEEL];
	ang_t ang_s1 [NWHEEL];

	logic [DV_W-1:0] drem_s [DIV_STEPS+1][NWHEEL];
	spd_t            q_s    [DIV_STEPS+1][NWHEEL];
	mag_t            dmag_s [DIV_STEPS+1][NWHEEL];
	ang_t            dang_s [DIV_STEPS+1][NWHEEL];
	mag_t            m_s    [DIV_STEPS+1];
	logic            need_s [DIV_STEPS+1];

	mag_t m_top;

	// First half of the max tree
	always_ff @(posedge clk) begin
		if (en) begin
			mab_s1 <= (mag[0] > mag[1]) ? mag[0] : mag[1];
			mcd_s1 <= (mag[2] > mag[3]) ? mag[2] : mag[3];
			mag_s1 <= mag;
			ang_s1 <= ang_in;
		end
	end

	// Largest magnitude and dividends mag * 2^14 + m / 2
	assign m_top = (mab_s1 > mcd_s1) ? mab_s1 : mcd_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]    <= m_top;
			need_s[0] <= m_top > ONE_Q14;
			for (int w = 0; w < NWHEEL; w++) begin
				drem_s[0][w] <= {1'b0, mag_s1[w], {FRAC{1'b0}}} + DV_W'(m_top >> 1);
				q_s[0][w]    <= '0;
				dmag_s[0][w] <= mag_s1[w];
				dang_s[0][w] <= ang_s1[w];
			end
		end
	end

	// Restoring divide, quotient bit DIV_STEPS-1-j at stage j
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		localparam int B = DIV_STEPS - 1 - j;
		logic [DV_W-1:0] dsh;
		assign dsh = DV_W'(m_s[j]) << B;

		always_ff @(posedge clk) begin
			if (en) begin
				m_s[j+1]    <= m_s[j];
				need_s[j+1] <= need_s[j];
				for (int w = 0; w < NWHEEL; w++) begin
					if (drem_s[j][w] >= dsh) begin
						drem_s[j+1][w] <= drem_s[j][w] - dsh;
						q_s[j+1][w]    <= q_s[j][w] | (SPD_W'(1) << B);
					end else begin
						drem_s[j+1][w] <= drem_s[j][w];
						q_s[j+1][w]    <= q_s[j][w];
					end
					dmag_s[j+1][w] <= dmag_s[j][w];
					dang_s[j+1][w] <= dang_s[j][w];
				end
			end
		end
	end

	// Output register: quotient only when the largest speed exceeds 1.0
	always_ff @(posedge clk) begin
		if (en) begin
			for (int w = 0; w < NWHEEL; w++) begin
				speed[w] <= need_s[DIV_STEPS] ? q_s[DIV_STEPS][w]
					: dmag_s[DIV_STEPS][w][SPD_W-1:0];
				angle[w] <= dang_s[DIV_STEPS][w];
			end
		end
	end

endmodule

FILE: tb/swerve_inverse_kinematics_top_test.sv
// Self-checking bench for swerve_inverse_kinematics_top: chassis commands in,
// per-wheel angle/speed out, compared with an in-bench fixed-point predictor.
// Depends on sik_pkg, sik_if and the core RTL.
module swerve_inverse_kinematics_top_test;
	import sik_pkg::*;

	localparam int CORDIC_STEPS = 16;
	localparam int PIPE_LAT     = 43;
	localparam int HOLD_CYCLES  = 400;
	localparam longint DEG      = 65536;

	typedef struct {
		ang_t angle [NWHEEL];
		spd_t speed [NWHEEL];
	} wheel_set_t;

	typedef struct {
		cmd_t x;
		cmd_t y;
		cmd_t r;
		bit   typed;
		ang_t angle;
		spd_t speed;
	} cmd_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	sik_cmd_if cmd();
	sik_res_if res();

	swerve_inverse_kinematics_top #(.CORDIC_STEPS(CORDIC_STEPS)) uut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd.sink), .res(res.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: half dimensions as the block holds them
	logic [CFG_W-1:0] half_len_q = HALF_RST;
	logic [CFG_W-1:0] half_wid_q = HALF_RST;

	wheel_set_t pending_sets[$];
	int fail_count = 0;
	int beats_in = 0;
	int beats_out = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	cmd_row_t dir_rows[$];

	longint arctan_deg [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	// Rounded integer root, half up
	function automatic longint unsigned root_round(longint unsigned s);
		longint unsigned r;
		longint unsigned b;
		longint unsigned rem;
		r = 0;
		rem = s;
		b = 64'd1 << 62;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (rem > r) r++;
		return r;
	endfunction

	// atan2(x, y) + 180 deg in 1/64 degree, vectoring rotations
	function automatic ang_t wheel_heading(longint x, longint y);
		longint u, v, z, t, du, dv;
		int n;
		if (x == 0 && y == 0) return ANG_W'(11520);
		if (y == 0) return (x > 0) ? ANG_W'(17280) : ANG_W'(5760);
		if (x == 0) return (y > 0) ? ANG_W'(11520) : ANG_W'(23040);
		n = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
		u = y * DEG;
		v = x * DEG;
		z = 0;
		// left half plane: flip and start from 180 degrees
		if (u < 0) begin
			u = -u;
			v = -v;
			z = 180 * DEG;
		end
		for (int i = 0; i < n; i++) begin
			du = v >>> i;
			dv = u >>> i;
			if (v >= 0) begin
				u += du; v -= dv; z += arctan_deg[i];
			end else begin
				u -= du; v += dv; z -= arctan_deg[i];
			end
		end
		t = z + 180 * DEG;
		while (t <= 0) t += 360 * DEG;
		while (t > 360 * DEG) t -= 360 * DEG;
		return ANG_W'((t + 512) >>> 10);
	endfunction

	function automatic wheel_set_t solve_wheels(cmd_t xs, cmd_t ys, cmd_t rot);
		wheel_set_t w;
		longint tl, tw;
		longint wx [4];
		longint wy [4];
		longint unsigned mag [4];
		longint unsigned m;
		tl = (longint'(rot) * longint'(half_len_q) + 8192) >>> 14;
		tw = (longint'(rot) * longint'(half_wid_q) + 8192) >>> 14;
		wx[0] = xs + tl; wy[0] = ys - tw;
		wx[1] = xs + tl; wy[1] = ys + tw;
		wx[2] = xs - tl; wy[2] = ys - tw;
		wx[3] = xs - tl; wy[3] = ys + tw;
		m = 0;
		for (int k = 0; k < 4; k++) begin
			mag[k] = root_round(longint'(wx[k] * wx[k] + wy[k] * wy[k]));
			if (mag[k] > m) m = mag[k];
		end
		for (int k = 0; k < 4; k++) begin
			w.angle[k] = wheel_heading(wx[k], wy[k]);
			w.speed[k] = (m > 16384) ? SPD_W'((mag[k] * 16384 + m / 2) / m)
				: SPD_W'(mag[k]);
		end
		return w;
	endfunction

	task automatic report_mismatch(string what, int k, int got, int want);
		$display("MISMATCH beat %0d wheel %0d %s: got %0d want %0d",
			beats_out, k, what, got, want);
		fail_count++;
	endtask

	task automatic check_result();
		wheel_set_t want;
		ang_t ga [NWHEEL];
		spd_t gs [NWHEEL];
		ga = '{res.front_right_angle, res.front_left_angle, res.rear_right_angle,
			res.rear_left_angle};
		gs = '{res.front_right_speed, res.front_left_speed, res.rear_right_speed,
			res.rear_left_speed};
		if (pending_sets.size() == 0) begin
			report_mismatch("unexpected beat", 0, 0, 0);
		end else begin
			want = pending_sets.pop_front();
			for (int k = 0; k < NWHEEL; k++) begin
				if (ga[k] !== want.angle[k]) report_mismatch("angle", k, ga[k], want.angle[k]);
				if (gs[k] !== want.speed[k]) report_mismatch("speed", k, gs[k], want.speed[k]);
			end
		end
		beats_out++;
	endtask

	// Result side: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (res.valid === 1'b1 && res.ready === 1'b1) check_result();
		if (hold_left > 0) begin
			hold_left--;
			res.ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic send_cmd(cmd_t x, cmd_t y, cmd_t r, bit typed, ang_t a, spd_t s);
		wheel_set_t w;
		// idle cycle by cycle before offering the beat
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.x_speed <= x;
		cmd.y_speed <= y;
		cmd.rotation <= r;
		do @(posedge clk); while (cmd.ready !== 1'b1);
		if (typed) begin
			for (int k = 0; k < NWHEEL; k++) begin
				w.angle[k] = a;
				w.speed[k] = s;
			end
		end else begin
			w = solve_wheels(x, y, r);
		end
		pending_sets.push_back(w);
		beats_in++;
	endtask

	task automatic drain();
		cmd.valid <= 1'b0;
		while (pending_sets.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_HALF_LENGTH) half_len_q = val;
		else half_wid_q = val;
	endtask

	function automatic cmd_t pick_field();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 10) return cmd_t'($urandom);
		if (sel < 20) begin
			case ($urandom_range(0, 2))
				0: return 16'sd0;
				1: return 16'sd16384;
				default: return -16'sd16384;
			endcase
		end
		return cmd_t'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	task automatic random_burst(int n);
		for (int i = 0; i < n; i++)
			send_cmd(pick_field(), pick_field(), pick_field(), 1'b0, '0, '0);
	endtask

	task automatic add_row(int x, int y, int r, bit typed, int a, int s);
		cmd_row_t row;
		row.x = cmd_t'(x);
		row.y = cmd_t'(y);
		row.r = cmd_t'(r);
		row.typed = typed;
		row.angle = ang_t'(a);
		row.speed = spd_t'(s);
		dir_rows.push_back(row);
	endtask

	initial begin
		cmd.valid = 1'b0;
		cmd.x_speed = '0;
		cmd.y_speed = '0;
		cmd.rotation = '0;
		res.ready = 1'b0;

		// Directed rows: zero vector, axis cases, extremes, raw out-of-range codes
		add_row(0, 0, 0, 1, 11520, 0);
		add_row(16384, 0, 0, 1, 17280, 16384);
		add_row(-16384, 0, 0, 1, 5760, 16384);
		add_row(0, 16384, 0, 1, 11520, 16384);
		add_row(0, -16384, 0, 1, 23040, 16384);
		add_row(1, 0, 0, 1, 17280, 1);
		add_row(0, -1, 0, 1, 23040, 1);
		add_row(0, 0, 16384, 0, 0, 0);
		add_row(0, 0, -16384, 0, 0, 0);
		add_row(16384, 16384, 16384, 0, 0, 0);
		add_row(-16384, -16384, -16384, 0, 0, 0);
		add_row(16384, -16384, 0, 0, 0, 0);
		add_row(-16384, 16384, 0, 0, 0, 0);
		add_row(-32768, -32768, -32768, 0, 0, 0);
		add_row(32767, 32767, 32767, 0, 0, 0);
		add_row(32767, -32768, 1, 0, 0, 0);
		add_row(1, -1, 1, 0, 0, 0);
		add_row(-1, 1, -1, 0, 0, 0);
		add_row(12345, -6789, 4321, 0, 0, 0);
		add_row(0, -5, 3, 0, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_cmd(dir_rows[i].x, dir_rows[i].y, dir_rows[i].r, dir_rows[i].typed,
				dir_rows[i].angle, dir_rows[i].speed);

		// Reset dimensions, sender idles less than receiver
		send_idle_pct = 37;
		recv_idle_pct = 49;
		random_burst(250);
		drain();

		// Extreme dimensions; long result hold-off fills the pipe
		write_reg(REG_HALF_LENGTH, 16'd0);
		write_reg(REG_HALF_WIDTH, 16'hFFFF);
		send_idle_pct = 49;
		recv_idle_pct = 37;
		hold_req = 1'b1;
		random_burst(250);
		drain();

		write_reg(REG_HALF_LENGTH, 16'hFFFF);
		write_reg(REG_HALF_WIDTH, 16'd0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_burst(125);
		drain();

		write_reg(REG_HALF_LENGTH, CFG_W'($urandom));
		write_reg(REG_HALF_WIDTH, CFG_W'($urandom));
		random_burst(125);
		drain();

		$display("Covered %0d commands and %0d wheel-set beats over four dimension settings,",
			beats_in, beats_out);
		$display("with stalls on both sides and one long output hold-off.");
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("Timeout with %0d beats outstanding", pending_sets.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
